### design/stf_pkg.sv
// Shared constants for the spline tangent frame block.
// Used by stf_norm and spline_tangent_frame; depends on nothing.
package stf_pkg;

  // Unit vector components are Q1.14 in 16 bits
  localparam int unsigned UNIT_W     = 16;
  localparam int unsigned UNIT_SHIFT = 14;

  // Magnitudes are scaled to 30 bits before the square root
  localparam int unsigned MANT_W = 30;

  // Quotient bits of a unit component (at most 16384)
  localparam int unsigned QUOT_W = 15;

  // Side index codes that flip part of the frame
  localparam logic [1:0] SIDE_FLIP_NORMAL = 2'd1;
  localparam logic [1:0] SIDE_FLIP_BINORM = 2'd3;

endpackage

### design/spline_tangent_frame.sv
// Top level of the Catmull-Rom tangent frame block: registers, spline
// derivative pipeline, cross product and output stage. Uses stf_pkg, stf_norm.
//
//  port group  dir  contents
//  s_axis      in   tdata: curve_param[16:0]; tuser: side_index[1:0]
//  m_axis      out  tdata: tangent xyz, normal xyz, binorm xyz, 16 bits each
//  apb         in   five registers, 3*COORD_WIDTH bits each, at byte address 8*i
//
// One transaction per cycle enters and leaves while m_axis does not stall;
// the pipeline length is set mostly by the root stages of the two
// normalizer levels in series, one root bit per stage.
// Reset clears all valid bits and the registers. A stall on m_axis freezes
// the whole pipeline and drops s_axis_tready in the same cycle.
module spline_tangent_frame #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [23:0]   s_axis_tdata,   // curve_param[16:0]
  input  logic [1:0]    s_axis_tuser,   // side_index[1:0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [143:0]  m_axis_tdata,   // tan x,y,z, normal x,y,z, binorm x,y,z
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned UW     = stf_pkg::UNIT_W;
  localparam int unsigned REG_W  = 3 * CW;
  localparam int unsigned NREG   = 5;
  localparam int unsigned T_W    = 17;
  localparam int unsigned WW     = 36;
  localparam int unsigned DW     = WW + CW + 2;
  localparam int unsigned CRW    = UW + CW + 1;
  localparam int unsigned NRM_NW = (CRW > stf_pkg::MANT_W) ? CRW : stf_pkg::MANT_W;
  localparam logic [T_W-1:0]       T_ONE = 17'h10000;
  localparam logic signed [WW-1:0] T_SQ  = WW'(64'h1_0000_0000);

  typedef enum logic [2:0] {
    REG_POINT_BEFORE = 3'd0,
    REG_POINT_START  = 3'd1,
    REG_POINT_END    = 3'd2,
    REG_POINT_AFTER  = 3'd3,
    REG_UP_VECTOR    = 3'd4
  } reg_idx_e;

  // configuration registers
  logic [REG_W-1:0] cfg_q [NREG];
  logic             wr_en;
  reg_idx_e         ridx;
  assign wr_en  = psel & penable & pwrite;
  assign ridx   = reg_idx_e'(paddr[5:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NREG; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (wr_en) begin
      unique case (ridx)
        REG_POINT_BEFORE: cfg_q[0] <= pwdata[REG_W-1:0];
        REG_POINT_START:  cfg_q[1] <= pwdata[REG_W-1:0];
        REG_POINT_END:    cfg_q[2] <= pwdata[REG_W-1:0];
        REG_POINT_AFTER:  cfg_q[3] <= pwdata[REG_W-1:0];
        REG_UP_VECTOR:    cfg_q[4] <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_POINT_BEFORE: prdata = 64'(cfg_q[0]);
      REG_POINT_START:  prdata = 64'(cfg_q[1]);
      REG_POINT_END:    prdata = 64'(cfg_q[2]);
      REG_POINT_AFTER:  prdata = 64'(cfg_q[3]);
      REG_UP_VECTOR:    prdata = 64'(cfg_q[4]);
      default:          prdata = '0;
    endcase
  end

  // coordinates of the points and the up vector
  logic signed [CW-1:0] pt [4][3];
  logic signed [CW-1:0] up [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 4; i++) begin
        pt[i][k] = cfg_q[i][k*CW +: CW];
      end
      up[k] = cfg_q[4][k*CW +: CW];
    end
  end

  // global advance: the whole pipeline moves when the output slot frees
  logic adv;
  logic ov_q;
  assign adv           = !ov_q || m_axis_tready;
  assign s_axis_tready = adv;

  // front valid chain: param, square, weights, products, sum, cross x2
  logic       tn_vld;
  logic [6:0] fv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (adv) begin
      fv_q <= {fv_q[5], tn_vld, fv_q[3:0], s_axis_tvalid};
    end
  end

  // derivative datapath
  logic [T_W-1:0]         t_in;
  logic [T_W-1:0]         t_q;
  logic [1:0]             sa_q, sb_q, sc_q, sd_q, se_q;
  logic [2*T_W-1:0]       tt_q;
  logic [T_W+15:0]        ts_q;
  logic signed [WW-1:0]   tt_s, ts_s;
  logic signed [WW-1:0]   w_d [4];
  logic signed [WW-1:0]   w_q [4];
  logic signed [WW+CW-1:0] pr_q [4][3];
  logic signed [DW-1:0]   dv_q [3];

  assign t_in = s_axis_tdata[T_W-1:0];

  always_comb begin
    tt_s   = signed'(WW'(tt_q));
    ts_s   = signed'(WW'(ts_q));
    w_d[0] = (ts_s <<< 2) - 3 * tt_s - T_SQ;
    w_d[1] = 9 * tt_s - 10 * ts_s;
    w_d[2] = (ts_s <<< 3) - 9 * tt_s + T_SQ;
    w_d[3] = 3 * tt_s - (ts_s <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q  <= (t_in > T_ONE) ? T_ONE : t_in;
      sa_q <= s_axis_tuser;
      tt_q <= t_q * t_q;
      ts_q <= {t_q, 16'b0};
      sb_q <= sa_q;
      w_q  <= w_d;
      sc_q <= sb_q;
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          pr_q[i][k] <= w_q[i] * pt[i][k];
        end
      end
      sd_q <= sc_q;
      for (int k = 0; k < 3; k++) begin
        dv_q[k] <= DW'(pr_q[0][k]) + DW'(pr_q[1][k]) + DW'(pr_q[2][k]) + DW'(pr_q[3][k]);
      end
      se_q <= sd_q;
    end
  end

  // tangent normalization
  logic [3*UW-1:0] tn_u;
  logic [1:0]      tn_side;
  stf_norm #(.IW(DW), .NW(DW), .PW(2)) u_tan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (fv_q[4]),
    .vec_i  ({dv_q[2], dv_q[1], dv_q[0]}),
    .pay_i  (se_q),
    .vld_o  (tn_vld),
    .unit_o (tn_u),
    .pay_o  (tn_side)
  );

  // cross product tangent x up
  logic signed [UW-1:0]    tc [3];
  logic signed [UW+CW-1:0] cp_q [6];
  logic signed [CRW-1:0]   cr_q [3];
  logic [3*UW-1:0]         xt1_q, xt2_q;
  logic [1:0]              xs1_q, xs2_q;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tc[k] = tn_u[k*UW +: UW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cp_q[0] <= tc[1] * up[2];
      cp_q[1] <= tc[2] * up[1];
      cp_q[2] <= tc[2] * up[0];
      cp_q[3] <= tc[0] * up[2];
      cp_q[4] <= tc[0] * up[1];
      cp_q[5] <= tc[1] * up[0];
      xt1_q   <= tn_u;
      xs1_q   <= tn_side;
      cr_q[0] <= CRW'(cp_q[0]) - CRW'(cp_q[1]);
      cr_q[1] <= CRW'(cp_q[2]) - CRW'(cp_q[3]);
      cr_q[2] <= CRW'(cp_q[4]) - CRW'(cp_q[5]);
      xt2_q   <= xt1_q;
      xs2_q   <= xs1_q;
    end
  end

  // normal and binormal normalization, same latency
  logic            nr_vld, bn_vld;
  logic [3*UW-1:0] nr_u, bn_u, tan_f;
  logic [1:0]      side_f;
  stf_norm #(.IW(CRW), .NW(NRM_NW), .PW(3*UW)) u_nrm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (fv_q[6]),
    .vec_i  ({cr_q[2], cr_q[1], cr_q[0]}),
    .pay_i  (xt2_q),
    .vld_o  (nr_vld),
    .unit_o (nr_u),
    .pay_o  (tan_f)
  );

  stf_norm #(.IW(CW), .NW(NRM_NW), .PW(2)) u_bin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (fv_q[6]),
    .vec_i  (cfg_q[REG_UP_VECTOR]),
    .pay_i  (xs2_q),
    .vld_o  (bn_vld),
    .unit_o (bn_u),
    .pay_o  (side_f)
  );

  // side flips and output register
  logic [9*UW-1:0] od_d;
  logic [9*UW-1:0] od_q;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      od_d[k*UW +: UW] = tan_f[k*UW +: UW];
      od_d[(3+k)*UW +: UW] = (side_f == stf_pkg::SIDE_FLIP_NORMAL) ?
                             UW'(0) - nr_u[k*UW +: UW] : nr_u[k*UW +: UW];
      od_d[(6+k)*UW +: UW] = (side_f == stf_pkg::SIDE_FLIP_BINORM) ?
                             UW'(0) - bn_u[k*UW +: UW] : bn_u[k*UW +: UW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= nr_vld & bn_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      od_q <= od_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

endmodule

### design/stf_norm.sv
// Pipelined 3-vector normalizer: scale, sum of squares, root, divide.
// One vector per cycle while en_i is high; depends on stf_pkg.
module stf_norm #(
  parameter int unsigned IW = 16,
  parameter int unsigned NW = 30,
  parameter int unsigned PW = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [3*IW-1:0]               vec_i,
  input  logic [PW-1:0]                 pay_i,
  output logic                          vld_o,
  output logic [3*stf_pkg::UNIT_W-1:0]  unit_o,
  output logic [PW-1:0]                 pay_o
);

  localparam int unsigned MT   = stf_pkg::MANT_W;
  localparam int unsigned DQ   = stf_pkg::QUOT_W;
  localparam int unsigned UW   = stf_pkg::UNIT_W;
  localparam int unsigned SW   = $clog2(NW);
  localparam int unsigned SQW  = 2 * MT + 2;
  localparam int unsigned SQX  = SQW + 1;
  localparam int unsigned RTN  = MT + 1;
  localparam int unsigned NUMW = MT + DQ;
  localparam int unsigned XW   = PW + 4;
  localparam int unsigned LAT  = SW + RTN + DQ + 6;

  // sideband layout: {payload, negative flags[2:0], zero flag}

  // valid chain
  logic [LAT-1:0] vl_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= '0;
    end else if (en_i) begin
      vl_q <= {vl_q[LAT-2:0], vld_i};
    end
  end
  assign vld_o = vl_q[LAT-1];

  // magnitudes and signs
  logic [IW-1:0] raw [3];
  logic [IW-1:0] inv [3];
  logic [NW-1:0] mag_d [3];
  logic [2:0]    neg_d;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      raw[k]   = vec_i[k*IW +: IW];
      inv[k]   = ~raw[k] + 1'b1;
      neg_d[k] = raw[k][IW-1];
      mag_d[k] = NW'(neg_d[k] ? inv[k] : raw[k]);
    end
  end

  logic [NW-1:0] ab_q [3];
  logic [2:0]    ng_q;
  logic [PW-1:0] p1_q;

  // largest magnitude
  logic [NW-1:0] b01;
  logic [NW-1:0] big_d;
  always_comb begin
    b01   = (ab_q[0] > ab_q[1]) ? ab_q[0] : ab_q[1];
    big_d = (b01 > ab_q[2]) ? b01 : ab_q[2];
  end

  // leading-one alignment, one power-of-two shift per stage
  logic [NW-1:0] sh_m_q [SW+1][3];
  logic [NW-1:0] sh_b_q [SW+1];
  logic [XW-1:0] sh_x_q [SW+1];
  logic [NW-1:0] shm_d  [SW][3];
  logic [NW-1:0] shb_d  [SW];
  always_comb begin
    for (int j = 0; j < SW; j++) begin
      if ((sh_b_q[j] >> (NW - (1 << (SW - 1 - j)))) == '0) begin
        shb_d[j] = sh_b_q[j] << (1 << (SW - 1 - j));
        for (int k = 0; k < 3; k++) begin
          shm_d[j][k] = sh_m_q[j][k] << (1 << (SW - 1 - j));
        end
      end else begin
        shb_d[j] = sh_b_q[j];
        for (int k = 0; k < 3; k++) begin
          shm_d[j][k] = sh_m_q[j][k];
        end
      end
    end
  end

  // squares and their sum
  logic [2*MT-1:0] sq_q [3];
  logic [MT-1:0]   mt_q [3];
  logic [XW-1:0]   mx_q;

  // root, one bit per stage
  logic [SQW-1:0] rx_q [RTN+1];
  logic [SQW-1:0] rr_q [RTN+1];
  logic [MT-1:0]  rm_q [RTN+1][3];
  logic [XW-1:0]  rs_q [RTN+1];
  logic [SQX-1:0] bitv  [RTN];
  logic [SQX-1:0] trial [RTN];
  logic [SQW-1:0] rxd   [RTN];
  logic [SQW-1:0] rrd   [RTN];
  always_comb begin
    for (int j = 0; j < RTN; j++) begin
      bitv[j]  = SQX'(1) << (2 * (RTN - 1 - j));
      trial[j] = {1'b0, rr_q[j]} + bitv[j];
      if ({1'b0, rx_q[j]} >= trial[j]) begin
        rxd[j] = rx_q[j] - trial[j][SQW-1:0];
        rrd[j] = (rr_q[j] >> 1) + bitv[j][SQW-1:0];
      end else begin
        rxd[j] = rx_q[j];
        rrd[j] = rr_q[j] >> 1;
      end
    end
  end

  // restoring division, one quotient bit per stage
  logic [NUMW-1:0] nm_q [DQ+1][3];
  logic [DQ-1:0]   qt_q [DQ+1][3];
  logic [RTN-1:0]  dn_q [DQ+1];
  logic [XW-1:0]   dx_q [DQ+1];
  logic [NUMW-1:0] dvs  [DQ];
  logic [NUMW-1:0] nmd  [DQ][3];
  logic [DQ-1:0]   qtd  [DQ][3];
  always_comb begin
    for (int j = 0; j < DQ; j++) begin
      dvs[j] = NUMW'(dn_q[j]) << (DQ - 1 - j);
      for (int k = 0; k < 3; k++) begin
        if (nm_q[j][k] >= dvs[j]) begin
          nmd[j][k] = nm_q[j][k] - dvs[j];
          qtd[j][k] = qt_q[j][k] | (DQ'(1) << (DQ - 1 - j));
        end else begin
          nmd[j][k] = nm_q[j][k];
          qtd[j][k] = qt_q[j][k];
        end
      end
    end
  end

  // signed result
  logic [UW-1:0] qu [3];
  logic [3*UW-1:0] un_d;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qu[k] = UW'(qt_q[DQ][k]);
      if (dx_q[DQ][0]) begin
        un_d[k*UW +: UW] = '0;
      end else if (dx_q[DQ][k+1]) begin
        un_d[k*UW +: UW] = UW'(0) - qu[k];
      end else begin
        un_d[k*UW +: UW] = qu[k];
      end
    end
  end

  logic [3*UW-1:0] un_q;
  logic [PW-1:0]   po_q;

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ab_q <= mag_d;
      ng_q <= neg_d;
      p1_q <= pay_i;

      sh_m_q[0] <= ab_q;
      sh_b_q[0] <= big_d;
      sh_x_q[0] <= {p1_q, ng_q, big_d == '0};
      for (int j = 0; j < SW; j++) begin
        sh_m_q[j+1] <= shm_d[j];
        sh_b_q[j+1] <= shb_d[j];
        sh_x_q[j+1] <= sh_x_q[j];
      end

      for (int k = 0; k < 3; k++) begin
        mt_q[k] <= sh_m_q[SW][k][NW-1 -: MT];
        sq_q[k] <= sh_m_q[SW][k][NW-1 -: MT] * sh_m_q[SW][k][NW-1 -: MT];
      end
      mx_q <= sh_x_q[SW];

      rx_q[0] <= SQW'(sq_q[0]) + SQW'(sq_q[1]) + SQW'(sq_q[2]);
      rr_q[0] <= '0;
      rm_q[0] <= mt_q;
      rs_q[0] <= mx_q;
      for (int j = 0; j < RTN; j++) begin
        rx_q[j+1] <= rxd[j];
        rr_q[j+1] <= rrd[j];
        rm_q[j+1] <= rm_q[j];
        rs_q[j+1] <= rs_q[j];
      end

      for (int k = 0; k < 3; k++) begin
        nm_q[0][k] <= (NUMW'(rm_q[RTN][k]) << stf_pkg::UNIT_SHIFT)
                      + NUMW'(rr_q[RTN][RTN-1:1]);
        qt_q[0][k] <= '0;
      end
      dn_q[0] <= rr_q[RTN][RTN-1:0];
      dx_q[0] <= rs_q[RTN];
      for (int j = 0; j < DQ; j++) begin
        nm_q[j+1] <= nmd[j];
        qt_q[j+1] <= qtd[j];
        dn_q[j+1] <= dn_q[j];
        dx_q[j+1] <= dx_q[j];
      end

      un_q <= un_d;
      po_q <= dx_q[DQ][XW-1:4];
    end
  end

  assign unit_o = un_q;
  assign pay_o  = po_q;

endmodule

### design/stf_checker.sv
// Port-level checks for spline_tangent_frame, attached with bind.
// Depends only on the top level's ports.
module stf_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata
);

  // every component lies within [-1, 1] in Q1.14
  logic signed [15:0] comp [9];
  logic [8:0]         rng_ok;
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      comp[k]   = m_axis_tdata[k*16 +: 16];
      rng_ok[k] = (comp[k] >= -16384) && (comp[k] <= 16384);
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> &rng_ok)
    else $error("unit component out of range");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipeline is frozen");

  // output stays idle through reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind spline_tangent_frame stf_checker u_stf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
